// File: rtl/npd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point distance package
// Shared sizes, codes and types for the nearest point distance engine.
// ----------------------------------------------------------------------------
package npd_pkg;

  // Table and coordinate sizes
  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 24;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 11;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int DIST_W     = 25;

  // Distance reported when no point is searched
  localparam logic [DIST_W-1:0] DIST_SAT = DIST_W'(29058991);

  // Request opcodes
  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_ROOT,
    ST_FINISH
  } state_e;

  // Square root unit result
  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_res_t;

endpackage

// File: rtl/npd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative integer square root
// Restoring digit-by-digit root: one result bit per cycle, ROOT_W result bits in all.
// ----------------------------------------------------------------------------
module npd_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [npd_pkg::SUM_W-1:0] radicand_i,
  output npd_pkg::sqrt_res_t       res_o
);
  import npd_pkg::*;

  localparam int REM_W  = ROOT_W + 2;
  localparam int ACC_W  = REM_W + 2;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [SUM_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [ACC_W-1:0]  acc, trial, acc_sub;
  logic              fits;

  // Bring down the next bit pair and try the new root bit
  always_comb begin
    acc     = {rem_q, rad_q[SUM_W-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    fits    = (acc >= trial);
    acc_sub = acc - trial;
    rem_d   = fits ? acc_sub[REM_W-1:0] : acc[REM_W-1:0];
    root_d  = {root_q[ROOT_W-2:0], fits};
  end

  // Hold the datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  // Count the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      step_q <= STEP_W'(ROOT_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.root = root_q;

endmodule

// File: rtl/nearest_point_distance.sv
`timescale 1ns / 1ps
// Load request: accepted and written to the point table, ready again the next cycle.
// Query request: the point walk and the squared distance pipeline (read, difference,
// square, sum, running minimum), then the start of the square root unit, the root itself
// and the output register; the result comes out valid with the block ready again.
// With point_count zero the sequencer skips the walk and the square root. Reset clears the
// count, sequencer and output valid; the point table holds no reset and gets no clearing.
// ----------------------------------------------------------------------------
// Nearest point distance engine
// Stores 3D points, returns floor Euclidean distance to the nearest (DIST_SAT if none).
// ----------------------------------------------------------------------------
module nearest_point_distance (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [npd_pkg::CNT_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [0:0]                          opcode_i,
  input  logic [9:0]                          point_index_i,
  input  logic signed [npd_pkg::COORD_BITS-1:0] coord_x_i,
  input  logic signed [npd_pkg::COORD_BITS-1:0] coord_y_i,
  input  logic signed [npd_pkg::COORD_BITS-1:0] coord_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [npd_pkg::DIST_W-1:0]          distance_o,
  output logic                                no_points_o
);
  import npd_pkg::*;

  localparam int CB = COORD_BITS;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  rd_idx_q;
  logic              zero_q;
  logic [CB-1:0]     qx_q, qy_q, qz_q;
  logic [3*CB-1:0]   mem_q [MAX_POINTS];
  logic [3*CB-1:0]   rdata_q;
  logic [CB-1:0]     dx_q, dy_q, dz_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q;
  logic [SUM_W-1:0]  sum_q, best_q;
  logic              best_vld_q;
  logic              rd_v_q, df_v_q, sq_v_q, sm_v_q;
  logic              out_valid_q, out_np_q;
  logic [DIST_W-1:0] out_dist_q;
  logic              in_acc, is_query, walk_last, pipe_busy;
  logic              mem_we, mem_re, sqrt_start, out_load;
  logic              load_ok;
  sqrt_res_t         sqrt_res;

  // Absolute coordinate difference, fits COORD_BITS unsigned
  function automatic logic [CB-1:0] abs_diff(logic [CB-1:0] a, logic [CB-1:0] b);
    logic [CB:0] d;
    logic [CB:0] n;
    d = {a[CB-1], a} - {b[CB-1], b};
    n = -d;
    return d[CB] ? n[CB-1:0] : d[CB-1:0];
  endfunction

  assign in_acc    = in_valid_i && in_ready_o;
  assign is_query  = (opcode_i == OP_QUERY);
  assign walk_last = ((rd_idx_q + CNT_W'(1)) == cnt_q);
  assign pipe_busy = rd_v_q || df_v_q || sq_v_q || sm_v_q;
  assign load_ok   = ({1'b0, point_index_i} < CNT_W'(MAX_POINTS));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_d = (cnt_q == '0) ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pipe_busy) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (sqrt_res.done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_WALK:   mem_re     = 1'b1;
      ST_DRAIN:  sqrt_start = !pipe_busy;
      ST_ROOT:   ;
      ST_FINISH: out_load   = !out_valid_q || out_ready_i;
      default:   ;
    endcase
  end

  assign mem_we = in_acc && !is_query && load_ok;

  // Hold state, count and walk index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      zero_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cnt_q <= (cfg_wdata_i > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cfg_wdata_i;
      end
      if (in_acc && is_query) begin
        rd_idx_q <= '0;
        zero_q   <= (cnt_q == '0);
      end else if (mem_re) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
    end
  end

  // Capture the query position
  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      qx_q <= coord_x_i;
      qy_q <= coord_y_i;
      qz_q <= coord_z_i;
    end
  end

  // Point table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[point_index_i[IDX_W-1:0]] <= {coord_x_i, coord_y_i, coord_z_i};
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_idx_q[IDX_W-1:0]];
    end
  end

  // Advance the pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q     <= 1'b0;
      df_v_q     <= 1'b0;
      sq_v_q     <= 1'b0;
      sm_v_q     <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      rd_v_q <= mem_re;
      df_v_q <= rd_v_q;
      sq_v_q <= df_v_q;
      sm_v_q <= sq_v_q;
      if (in_acc && is_query) begin
        best_vld_q <= 1'b0;
      end else if (sm_v_q) begin
        best_vld_q <= 1'b1;
      end
    end
  end

  // Squared distance pipeline and running minimum
  always_ff @(posedge clk_i) begin
    dx_q  <= abs_diff(qx_q, rdata_q[3*CB-1:2*CB]);
    dy_q  <= abs_diff(qy_q, rdata_q[2*CB-1:CB]);
    dz_q  <= abs_diff(qz_q, rdata_q[CB-1:0]);
    sqx_q <= SQ_W'(dx_q) * SQ_W'(dx_q);
    sqy_q <= SQ_W'(dy_q) * SQ_W'(dy_q);
    sqz_q <= SQ_W'(dz_q) * SQ_W'(dz_q);
    sum_q <= SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q);
    if (sm_v_q && (!best_vld_q || (sum_q < best_q))) begin
      best_q <= sum_q;
    end
  end

  npd_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (best_q),
    .res_o      (sqrt_res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_dist_q <= zero_q ? DIST_SAT : DIST_W'(sqrt_res.root);
      out_np_q   <= zero_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = out_dist_q;
  assign no_points_o = out_np_q;

endmodule

// File: rtl/npd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point distance port checker
// Watches the top level ports for sequencing and result rules.
// ----------------------------------------------------------------------------
module npd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [0:0]                          opcode_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [npd_pkg::DIST_W-1:0]          distance_o,
  input logic                                no_points_o
);
  import npd_pkg::*;

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o) && $stable(no_points_o))
    else $error("stalled result changed");

  // Empty search reports the saturated distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_points_o |-> distance_o == DIST_SAT)
    else $error("no_points without saturated distance");

  // Query occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == OP_QUERY |=> !in_ready_o)
    else $error("ready after query request");

  // Load completes at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == OP_LOAD |=> in_ready_o)
    else $error("not ready after load request");

  // New result only comes out of a busy block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without pending query");

endmodule

bind nearest_point_distance npd_checker u_npd_checker (.*);
